>>> design/frustum_sphere_cull_assert.svh
// assertion macros shared by the checker
`ifndef FRUSTUM_SPHERE_CULL_ASSERT_SVH
`define FRUSTUM_SPHERE_CULL_ASSERT_SVH

// same-cycle implication
`define FSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/fsc_pkg.sv
package fsc_pkg;

    localparam int PLANE_COUNT = 6;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TEST = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        radius;
    } t_in_item;

    typedef struct packed {
        logic               inside_res;
        logic [5:0]         plane_mask;
        logic signed [31:0] dist_left;
        logic signed [31:0] dist_right;
        logic signed [31:0] dist_bottom;
        logic signed [31:0] dist_top;
        logic signed [31:0] dist_near;
        logic signed [31:0] dist_far;
        logic               degenerate;
    } t_out_item;

    // front queue head as seen by the back end
    typedef struct packed {
        logic     valid;
        logic     is_test;
        logic     empty;
        t_in_item item;
    } t_front_head;

endpackage

>>> design/fsc_front.sv
module fsc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  fsc_pkg::t_in_item   i_item,
    output fsc_pkg::t_front_head o_head,
    input  logic                i_take
);
    import fsc_pkg::*;

    t_in_item   r_item [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_take;

    assign o_full  = (r_count == 2'd2);
    assign w_push  = i_push && !o_full;
    assign w_take  = i_take && (r_count != 2'd0);

    assign o_head.valid   = (r_count != 2'd0);
    assign o_head.empty   = (r_count == 2'd0);
    assign o_head.item    = r_item[r_rptr];
    assign o_head.is_test = (r_item[r_rptr].kind == KIND_TEST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_item[r_wptr] <= i_item;
                r_wptr         <= ~r_wptr;
            end
            if (w_take) begin
                r_rptr <= ~r_rptr;
            end
            case ({w_push, w_take})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> design/fsc_back.sv
module fsc_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fsc_pkg::t_front_head i_head,
    output logic                 o_take,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_data,
    output logic                 o_empty,
    input  logic                 i_pop,
    output fsc_pkg::t_out_item   o_out
);
    import fsc_pkg::*;

    localparam int NW  = 32 + FRAC_BITS;
    localparam int DCW = $clog2(NW);

    typedef enum logic [3:0] {
        S_IDLE, S_RAW, S_SQ_MUL, S_SQ_ACC, S_SQRT, S_LEN, S_DIV_INIT, S_DIV,
        S_DIV_WR, S_T_MUL, S_T_ACC, S_T_FIN, S_OUT
    } t_state;

    t_state             r_state;
    logic               r_norm;
    logic signed [31:0] r_mat [16];
    logic signed [31:0] r_pl [24];
    logic [5:0]         r_zero;
    logic [2:0]         r_p;
    logic [1:0]         r_k;
    logic signed [31:0] r_coef [4];
    logic signed [63:0] r_prod;
    logic [63:0]        r_ss;
    logic [63:0]        r_n;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [4:0]         r_it;
    logic [33:0]        r_rem;
    logic [NW-1:0]      r_num;
    logic [NW-1:0]      r_quo;
    logic [DCW-1:0]     r_dcnt;
    logic signed [65:0] r_tacc;
    logic signed [31:0] r_pos [3];
    logic [30:0]        r_rad;
    logic signed [31:0] r_dist [6];
    logic [5:0]         r_mask;
    logic               r_ovalid;
    t_out_item          r_out;

    logic signed [31:0] w_raw [4];
    logic signed [31:0] w_ma;
    logic signed [31:0] w_mb;
    logic signed [63:0] w_mul;
    logic [63:0]        w_trial;
    logic [33:0]        w_rem_sh;
    logic [33:0]        w_len;
    logic               w_qbit;
    logic [31:0]        w_mag;
    logic [31:0]        w_qsat;
    logic signed [65:0] w_sh;
    logic signed [66:0] w_dist;
    logic signed [66:0] w_sum;
    logic signed [31:0] w_dsat;
    logic               w_load_out;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            sat33 = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat33 = v[31:0];
        end
    endfunction

    // row sums and differences for plane r_p (plane 4 takes row 2 alone)
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic signed [32:0] m0, m1, m2, m3;
            m0 = {r_mat[k*4+0][31], r_mat[k*4+0]};
            m1 = {r_mat[k*4+1][31], r_mat[k*4+1]};
            m2 = {r_mat[k*4+2][31], r_mat[k*4+2]};
            m3 = {r_mat[k*4+3][31], r_mat[k*4+3]};
            case (r_p)
                3'd0:    w_raw[k] = sat33(m3 + m0);
                3'd1:    w_raw[k] = sat33(m3 - m0);
                3'd2:    w_raw[k] = sat33(m3 + m1);
                3'd3:    w_raw[k] = sat33(m3 - m1);
                3'd4:    w_raw[k] = sat33(m2);
                default: w_raw[k] = sat33(m3 - m2);
            endcase
        end
    end

    // shared multiplier
    always_comb begin
        if (r_state == S_T_MUL) begin
            w_ma = r_pl[{r_p, r_k}];
            w_mb = r_pos[r_k];
        end else begin
            w_ma = r_coef[r_k];
            w_mb = r_coef[r_k];
        end
    end
    assign w_mul = w_ma * w_mb;

    assign w_trial  = r_res + r_bit;
    assign w_rem_sh = {r_rem[32:0], r_num[NW-1]};
    assign w_len    = {1'b0, r_res[32:0]};
    assign w_qbit   = (w_rem_sh >= w_len);
    assign w_mag    = r_coef[r_k][31] ? 32'(-r_coef[r_k]) : 32'(r_coef[r_k]);

    // quotient saturated to 2^31
    assign w_qsat = (r_quo >= NW'(64'h8000_0000)) ? 32'h8000_0000 : r_quo[31:0];

    assign w_sh   = r_tacc >>> FRAC_BITS;
    assign w_dist = {w_sh[65], w_sh} + {{35{r_pl[{r_p, 2'd3}][31]}}, r_pl[{r_p, 2'd3}]};
    assign w_sum  = w_dist + {36'd0, r_rad};
    assign w_dsat = (w_dist > 67'sd2147483647) ? 32'sh7fff_ffff :
                    (w_dist < -67'sd2147483648) ? 32'sh8000_0000 : w_dist[31:0];

    assign o_take      = (r_state == S_IDLE) && i_head.valid;
    assign o_cfg_ready = (r_state == S_IDLE) && i_head.empty;
    assign o_empty     = !r_ovalid;
    assign o_out       = r_out;
    assign w_load_out  = (r_state == S_OUT) && (!r_ovalid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_norm   <= 1'b1;
            r_zero   <= 6'd0;
            r_ovalid <= 1'b0;
            r_p      <= 3'd0;
            r_k      <= 2'd0;
            for (int i = 0; i < 16; i++) r_mat[i] <= '0;
            for (int i = 0; i < 24; i++) r_pl[i] <= '0;
        end else begin
            if (i_pop && r_ovalid && !w_load_out) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        r_norm  <= i_cfg_data;
                        r_zero  <= 6'd0;
                        r_p     <= 3'd0;
                        r_state <= S_RAW;
                    end else if (i_head.valid) begin
                        if (i_head.is_test) begin
                            r_pos[0] <= i_head.item.pos_x;
                            r_pos[1] <= i_head.item.pos_y;
                            r_pos[2] <= i_head.item.pos_z;
                            r_rad    <= i_head.item.radius;
                            r_p      <= 3'd0;
                            r_k      <= 2'd0;
                            r_tacc   <= '0;
                            r_state  <= S_T_MUL;
                        end else begin
                            r_mat[i_head.item.element_index] <= i_head.item.element_value;
                            r_zero  <= 6'd0;
                            r_p     <= 3'd0;
                            r_state <= S_RAW;
                        end
                    end
                end
                S_RAW: begin
                    for (int k = 0; k < 4; k++) r_coef[k] <= w_raw[k];
                    if (!r_norm) begin
                        for (int k = 0; k < 4; k++) r_pl[{r_p, 2'(k)}] <= w_raw[k];
                        r_p     <= r_p + 3'd1;
                        r_state <= (r_p == 3'd5) ? S_IDLE : S_RAW;
                    end else begin
                        r_ss    <= '0;
                        r_k     <= 2'd0;
                        r_state <= S_SQ_MUL;
                    end
                end
                S_SQ_MUL: begin
                    r_prod  <= w_mul;
                    r_state <= S_SQ_ACC;
                end
                S_SQ_ACC: begin
                    r_ss <= r_ss + 64'(r_prod);
                    if (r_k == 2'd2) begin
                        r_n     <= r_ss + 64'(r_prod);
                        r_res   <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_it    <= 5'd0;
                        r_state <= S_SQRT;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_SQ_MUL;
                    end
                end
                S_SQRT: begin
                    if (r_n >= w_trial) begin
                        r_n   <= r_n - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_it  <= r_it + 5'd1;
                    if (r_it == 5'd31) begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    if (r_res == 64'd0) begin
                        for (int k = 0; k < 4; k++) r_pl[{r_p, 2'(k)}] <= '0;
                        r_zero[r_p] <= 1'b1;
                        r_p         <= r_p + 3'd1;
                        r_state     <= (r_p == 3'd5) ? S_IDLE : S_RAW;
                    end else begin
                        r_k     <= 2'd0;
                        r_state <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT: begin
                    r_num   <= {w_mag, FRAC_BITS'(0)};
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= w_qbit ? (w_rem_sh - w_len) : w_rem_sh;
                    r_quo  <= {r_quo[NW-2:0], w_qbit};
                    r_num  <= r_num << 1;
                    r_dcnt <= r_dcnt + DCW'(1);
                    if (r_dcnt == DCW'(NW - 1)) begin
                        r_state <= S_DIV_WR;
                    end
                end
                S_DIV_WR: begin
                    if (r_coef[r_k][31]) begin
                        r_pl[{r_p, r_k}] <= 32'(-w_qsat);
                    end else begin
                        r_pl[{r_p, r_k}] <= w_qsat[31] ? 32'sh7fff_ffff : w_qsat;
                    end
                    if (r_k == 2'd3) begin
                        r_p     <= r_p + 3'd1;
                        r_state <= (r_p == 3'd5) ? S_IDLE : S_RAW;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_DIV_INIT;
                    end
                end
                S_T_MUL: begin
                    r_prod  <= w_mul;
                    r_state <= S_T_ACC;
                end
                S_T_ACC: begin
                    r_tacc <= r_tacc + {{2{r_prod[63]}}, r_prod};
                    if (r_k == 2'd2) begin
                        r_state <= S_T_FIN;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_T_MUL;
                    end
                end
                S_T_FIN: begin
                    r_dist[r_p] <= w_dsat;
                    r_mask[r_p] <= !w_sum[66];
                    r_k         <= 2'd0;
                    r_tacc      <= '0;
                    r_p         <= r_p + 3'd1;
                    r_state     <= (r_p == 3'd5) ? S_OUT : S_T_MUL;
                end
                S_OUT: begin
                    if (w_load_out) begin
                        r_out.inside_res  <= (r_mask == 6'h3f);
                        r_out.plane_mask  <= r_mask;
                        r_out.dist_left   <= r_dist[0];
                        r_out.dist_right  <= r_dist[1];
                        r_out.dist_bottom <= r_dist[2];
                        r_out.dist_top    <= r_dist[3];
                        r_out.dist_near   <= r_dist[4];
                        r_out.dist_far    <= r_dist[5];
                        r_out.degenerate  <= r_norm && (r_zero != 6'd0);
                        r_ovalid          <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/frustum_sphere_cull.sv
// frustum sphere culler, Q16.16 fixed point by default
// input queue side: drive i_in and raise i_push; a beat is taken when o_full is low.
//   kind 0 loads one matrix element and re-derives the six planes, kind 1 tests a sphere.
// result queue side: while o_empty is low o_out holds the oldest result; i_pop takes it.
//   only test beats produce a result.
// config channel: i_cfg_valid / o_cfg_ready carry normalize_planes; a write re-derives
//   the planes. ready is high only when the block is idle with its input queue empty.
// in the back end a sphere test runs six planes, three products each through one shared
//   32x32 multiplier (a multiply step and an accumulate step each) plus a step to finish
//   each distance, then its result is loaded into the result register.
// a load re-derives the six planes; when normalizing, each plane also runs a bit-serial
//   square root and, per coefficient, a bit-serial divider of NW = 32 + FRAC_BITS bits.
// a two-beat input queue keeps accepting while the back end works or the result stalls;
//   a stalled result blocks the next test only at its final step.
// reset (synchronous, active low) clears the matrix and planes to zero, sets
//   normalize_planes to 1 and empties both queues.
module frustum_sphere_cull #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  fsc_pkg::t_in_item  i_in,
    output logic               o_empty,
    input  logic               i_pop,
    output fsc_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import fsc_pkg::*;

    t_front_head w_head;
    logic        w_take;

    fsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_item  (i_in),
        .o_head  (w_head),
        .i_take  (w_take)
    );

    fsc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_take      (w_take),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out)
    );

endmodule

>>> design/fsc_checker.sv
`include "frustum_sphere_cull_assert.svh"

module fsc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_push,
    input logic               o_full,
    input fsc_pkg::t_in_item  i_in,
    input logic               o_empty,
    input logic               i_pop,
    input fsc_pkg::t_out_item o_out,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic               i_cfg_data
);
    import fsc_pkg::*;

    `FSC_ASSERT_NOW(a_inside_mask, !o_empty, o_out.inside_res == (o_out.plane_mask == 6'h3f), "inside flag disagrees with mask")
    `FSC_ASSERT_NOW(a_left_visible, !o_empty && !o_out.dist_left[31], o_out.plane_mask[0], "nonnegative left distance not visible")
    `FSC_ASSERT_NOW(a_cfg_not_full, o_cfg_ready, !o_full, "config ready while input queue full")
    `FSC_ASSERT_NEXT(a_result_hold, !o_empty && !i_pop, !o_empty && $stable(o_out), "result changed while stalled")

endmodule

bind frustum_sphere_cull fsc_checker u_fsc_checker (.*);

>>> dv/frustum_sphere_cull_tb.sv
`default_nettype none

module frustum_sphere_cull_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsc_pkg::*;

    localparam int FRAC = 16;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 2500;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_push;
    logic      o_full;
    t_in_item  i_in;
    logic      o_empty;
    logic      i_pop;
    t_out_item o_out;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic      i_cfg_data;

    frustum_sphere_cull dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_in        (i_in),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // predictor state
    logic     norm_en;
    int       mat[16];
    int       pl[6][4];
    logic [5:0] zero_flags;

    t_in_item  items_pending[$];
    t_out_item cull_expected[$];

    int     errors;
    int     loads_taken;
    int     tests_taken;
    int     results_seen;
    int     cfg_writes;
    longint cycles;
    logic   in_fire;
    int     gap_left;
    int     stall_left;
    logic   held;
    logic   calm;

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return int'(v);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void derive_planes();
        longint m0, m1, m2, m3, c;
        longint unsigned ss, len, mag, q;
        zero_flags = '0;
        for (int k = 0; k < 4; k++) begin
            m0 = mat[k*4+0];
            m1 = mat[k*4+1];
            m2 = mat[k*4+2];
            m3 = mat[k*4+3];
            pl[0][k] = sat32(m3 + m0);
            pl[1][k] = sat32(m3 - m0);
            pl[2][k] = sat32(m3 + m1);
            pl[3][k] = sat32(m3 - m1);
            pl[4][k] = sat32(m2);
            pl[5][k] = sat32(m3 - m2);
        end
        if (!norm_en) return;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            ss = 0;
            for (int k = 0; k < 3; k++) begin
                c = pl[p][k];
                mag = (c < 0) ? -c : c;
                ss += mag * mag;
            end
            len = isqrt(ss);
            if (len == 0) begin
                zero_flags[p] = 1'b1;
                for (int k = 0; k < 4; k++) pl[p][k] = 0;
            end else begin
                for (int k = 0; k < 4; k++) begin
                    c = pl[p][k];
                    mag = (c < 0) ? -c : c;
                    q = (mag << FRAC) / len;
                    if (q > 64'h80000000) q = 64'h80000000;
                    pl[p][k] = sat32((c < 0) ? -longint'(q) : longint'(q));
                end
            end
        end
    endfunction

    function automatic void cull_predict(t_in_item it);
        t_out_item r;
        longint pos[3];
        longint hi, lo, prod, q, dist_q;
        int dists[6];
        if (it.kind == KIND_LOAD) begin
            mat[it.element_index] = it.element_value;
            derive_planes();
            return;
        end
        pos[0] = it.pos_x;
        pos[1] = it.pos_y;
        pos[2] = it.pos_z;
        r = '0;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            hi = pl[p][3];
            lo = 0;
            for (int k = 0; k < 3; k++) begin
                prod = longint'(pl[p][k]) * pos[k];
                q = prod >>> FRAC;
                lo += prod - (q <<< FRAC);
                hi += q;
            end
            dist_q = hi + (lo >>> FRAC);
            if (dist_q + longint'({33'b0, it.radius}) >= 0) r.plane_mask[p] = 1'b1;
            dists[p] = sat32(dist_q);
        end
        r.inside_res  = (r.plane_mask == 6'h3f);
        r.dist_left   = dists[0];
        r.dist_right  = dists[1];
        r.dist_bottom = dists[2];
        r.dist_top    = dists[3];
        r.dist_near   = dists[4];
        r.dist_far    = dists[5];
        r.degenerate  = norm_en && (zero_flags != 0);
        cull_expected.push_back(r);
    endfunction

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // sample side
    always @(posedge i_clk) begin
        t_out_item e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Test completed with failures");
            $finish;
        end
        in_fire <= i_rst_n && i_push && !o_full;
        if (i_rst_n && i_push && !o_full) begin
            if (i_in.kind == KIND_LOAD) loads_taken++;
            else tests_taken++;
            cull_predict(i_in);
        end
        if (i_rst_n && i_pop && !o_empty) begin
            results_seen++;
            if (cull_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %p", $time, o_out);
            end else begin
                e = cull_expected.pop_front();
                check_field("inside_res", longint'(e.inside_res),
                            longint'(o_out.inside_res));
                check_field("plane_mask", longint'(e.plane_mask),
                            longint'(o_out.plane_mask));
                check_field("dist_left", longint'(e.dist_left), longint'(o_out.dist_left));
                check_field("dist_right", longint'(e.dist_right),
                            longint'(o_out.dist_right));
                check_field("dist_bottom", longint'(e.dist_bottom),
                            longint'(o_out.dist_bottom));
                check_field("dist_top", longint'(e.dist_top), longint'(o_out.dist_top));
                check_field("dist_near", longint'(e.dist_near), longint'(o_out.dist_near));
                check_field("dist_far", longint'(e.dist_far), longint'(o_out.dist_far));
                check_field("degenerate", longint'(e.degenerate),
                            longint'(o_out.degenerate));
            end
        end
    end

    // drive side, input
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire && items_pending.size() > 0) void'(items_pending.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_push <= 1'b0;
            end else if (items_pending.size() == 0) begin
                i_push <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                gap_left <= $urandom_range(1, 14) - 1;
                i_push <= 1'b0;
            end else begin
                i_push <= 1'b1;
                i_in <= items_pending[0];
            end
        end
    end

    // drive side, result
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!held && results_seen >= 60) begin
                held <= 1'b1;
                stall_left <= 600;
                i_pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(1, 14) - 1;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    function automatic t_in_item rand_item();
        t_in_item it;
        it.kind          = 1'($urandom_range(0, 1));
        it.element_index = 4'($urandom_range(0, 15));
        it.element_value = $urandom;
        it.pos_x         = $urandom;
        it.pos_y         = $urandom;
        it.pos_z         = $urandom;
        it.radius        = 31'($urandom);
        return it;
    endfunction

    task automatic add_load(int idx, int val);
        t_in_item it;
        it = rand_item();
        it.kind = KIND_LOAD;
        it.element_index = 4'(idx);
        it.element_value = val;
        items_pending.push_back(it);
    endtask

    task automatic add_test(int x, int y, int z, int r);
        t_in_item it;
        it = rand_item();
        it.kind = KIND_TEST;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.radius = 31'(r);
        items_pending.push_back(it);
    endtask

    function automatic int small_q(int units);
        return $urandom_range(0, units * 2 * 65536) - units * 65536;
    endfunction

    // a plausible matrix update followed by culling tests
    task automatic add_scene();
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_load($urandom_range(0, 15), small_q(4));
        n = $urandom_range(6, 14);
        for (int i = 0; i < n; i++)
            add_test(small_q(60), small_q(60), small_q(60), $urandom_range(0, 10 * 65536));
    endtask

    task automatic add_random(int count);
        int done;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 9) < 8) begin
                add_scene();
            end else begin
                items_pending.push_back(rand_item());
            end
            done = items_pending.size();
        end
    endtask

    task automatic drain();
        wait (items_pending.size() == 0 && !i_push);
        wait (cull_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_norm(logic v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        norm_en = v;
        derive_planes();
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_pop = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        norm_en = 1'b1;
        foreach (mat[i]) mat[i] = 0;
        foreach (pl[p, k]) pl[p][k] = 0;
        zero_flags = '0;
        errors = 0;
        loads_taken = 0;
        tests_taken = 0;
        results_seen = 0;
        cfg_writes = 0;
        cycles = 0;
        in_fire = 1'b0;
        gap_left = 0;
        stall_left = 0;
        held = 1'b0;
        calm = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero planes, saturating sums, degenerate normals, extreme spheres
        add_test(0, 0, 0, 0);
        add_test(32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h7fffffff);
        add_load(0, 32'h7fffffff);
        add_load(3, 32'h7fffffff);
        add_test(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
        add_load(7, 32'h80000000);
        add_load(5, 32'h7fffffff);
        add_test(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
        add_load(10, 32'h80000000);
        add_load(15, 32'h00010000);
        add_test(32'h00010000, 32'hffff0000, 32'h00000001, 1);
        add_load(0, 32'h00010000);
        add_load(5, 32'h00010000);
        add_load(10, 32'h00010000);
        add_load(3, 0);
        add_load(7, 0);
        add_test(32'h00008000, 32'hffff8000, 32'h00020000, 0);
        add_test(32'h00200000, 0, 0, 32'h00010000);
        add_test(32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
        add_load(15, 32'h80000000);
        add_test(0, 0, 0, 31'h7fffffff);
        drain();

        write_norm(1'b0);
        add_test(32'h7fffffff, 32'h80000000, 32'h12345678, 0);
        add_random(330);
        drain();
        write_norm(1'b1);
        add_random(330);
        drain();
        write_norm(1'b0);
        add_random(330);
        drain();
        write_norm(1'b1);
        calm = 1'b1;
        add_random(330);
        drain();

        $display("covered %0d matrix loads, %0d sphere tests, %0d results, %0d config writes",
                 loads_taken, tests_taken, results_seen, cfg_writes);
        if (errors == 0 && cull_expected.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, cull_expected.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
